@@ rtl/tgr_pkg.sv @@
// Shared types, constants and helpers for the text glyph row renderer.
`default_nettype none
package tgr_pkg;

    localparam int GLYPH_COUNT = 256;
    localparam int FONT_ROWS   = 16;
    localparam int COORD_BITS  = 13;

    localparam int STORE_DEPTH = GLYPH_COUNT * FONT_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COORD_W     = 13;
    localparam int COLOR_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;

    localparam logic [COORD_W-1:0] COORD_MASK =
        (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

    typedef enum logic
    {
        MODE_LOAD = 1'b0,
        MODE_DRAW = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_SCALE_SHIFT   = 3'd2,
        CFG_NINTH_COLUMN  = 3'd3,
        CFG_KEY_COLOR     = 3'd4,
        CFG_CANVAS_ENABLE = 3'd5,
        CFG_GRID_COLUMNS  = 3'd6,
        CFG_GRID_ROWS     = 3'd7
    } cfg_idx_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [1:0]         scale_shift;
        logic               ninth_column;
        logic [COLOR_W-1:0] key_color;
        logic               canvas_enable;
        logic [7:0]         grid_columns;
        logic [7:0]         grid_rows;
    } cfg_t;

    // Context of one draw request between the font fetch and the pixel emitter
    typedef struct packed
    {
        logic [COLOR_W-1:0] foreground;
        logic [COLOR_W-1:0] background;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] pixel_y;
        logic               code_ok;
        logic               ninth_repeat;
    } ctx_t;

    // Scale code three saturates to 4x
    function automatic logic [1:0] eff_shift(input logic [1:0] scale_shift);
        return (scale_shift == 2'd3) ? 2'd2 : scale_shift;
    endfunction

    // Scaled cell width in pixels: 8, 9, 16, 18, 32 or 36
    function automatic logic [5:0] cell_width(input cfg_t cfg);
        logic [5:0] fcols;
        fcols = 6'd8 + {5'd0, cfg.ninth_column};
        return fcols << eff_shift(cfg.scale_shift);
    endfunction

endpackage
`default_nettype wire

@@ rtl/tgr_req_if.sv @@
// Request channel: one load or draw item.
`default_nettype none
interface tgr_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  code;
    logic [5:0]  line;
    logic [7:0]  font_byte;
    logic [31:0] foreground;
    logic [31:0] background;
    logic [7:0]  column;
    logic [7:0]  row;

    modport source
    (
        output valid, mode, code, line, font_byte, foreground, background, column, row,
        input  ready
    );

    modport sink
    (
        input  valid, mode, code, line, font_byte, foreground, background, column, row,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/tgr_pix_if.sv @@
// Result channel: one rendered pixel.
`default_nettype none
interface tgr_pix_if;
    logic        valid;
    logic        ready;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [31:0] color;
    logic        from_canvas;
    logic        last_pixel;

    modport source
    (
        output valid, pixel_x, pixel_y, color, from_canvas, last_pixel,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_x, pixel_y, color, from_canvas, last_pixel,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/tgr_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/tgr_fetch.sv @@
// Request stage: font store writes, draw checks, font row read and cell geometry.
`default_nettype none
module tgr_fetch (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tgr_req_if.sink                           req,
    input  wire tgr_pkg::cfg_t                cfg,
    input  wire logic                         take,
    output logic                              ram_we,
    output logic      [tgr_pkg::ADDR_W-1:0]   ram_waddr,
    output logic      [7:0]                   ram_wdata,
    output logic                              ram_re,
    output logic      [tgr_pkg::ADDR_W-1:0]   ram_raddr,
    output logic                              ctx_valid,
    output tgr_pkg::ctx_t                     ctx
);

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    tgr_pkg::ctx_t                ctx_reg;
    tgr_pkg::ctx_t                ctx_next;
    logic                         accept;
    logic                         draw_ok;
    logic                         code_ok;
    logic [1:0]                   sh;
    logic [5:0]                   frow;
    logic [5:0]                   cell_w;
    logic [6:0]                   cell_h;
    logic [13:0]                  col_off;
    logic [14:0]                  row_off;
    logic [tgr_pkg::COORD_W-1:0]  base_x;
    logic [tgr_pkg::COORD_W-1:0]  py;

    assign req.ready = !s1_valid_reg || take;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        sh      = tgr_pkg::eff_shift(cfg.scale_shift);
        frow    = req.line >> sh;
        cell_w  = tgr_pkg::cell_width(cfg);
        cell_h  = 7'(tgr_pkg::FONT_ROWS) << sh;
        code_ok = {1'b0, req.code} < 9'(tgr_pkg::GLYPH_COUNT);
        col_off = 14'(req.column) * 14'(cell_w);
        row_off = 15'(req.row) * 15'(cell_h);
        base_x  = (cfg.origin_x + col_off[tgr_pkg::COORD_W-1:0]) & tgr_pkg::COORD_MASK;
        py      = (cfg.origin_y + row_off[tgr_pkg::COORD_W-1:0]
                   + tgr_pkg::COORD_W'(req.line)) & tgr_pkg::COORD_MASK;
        draw_ok = (req.mode == tgr_pkg::MODE_DRAW)
                  && (req.column < cfg.grid_columns)
                  && (req.row < cfg.grid_rows)
                  && (frow < 6'(tgr_pkg::FONT_ROWS));

        ram_we    = accept && (req.mode == tgr_pkg::MODE_LOAD)
                    && (req.line < 6'(tgr_pkg::FONT_ROWS)) && code_ok;
        ram_waddr = tgr_pkg::ADDR_W'(tgr_pkg::ADDR_W'(req.code) * tgr_pkg::ADDR_W'(tgr_pkg::FONT_ROWS)
                    + tgr_pkg::ADDR_W'(req.line));
        ram_wdata = req.font_byte;
        ram_re    = accept && draw_ok;
        ram_raddr = tgr_pkg::ADDR_W'(tgr_pkg::ADDR_W'(req.code) * tgr_pkg::ADDR_W'(tgr_pkg::FONT_ROWS)
                    + tgr_pkg::ADDR_W'(frow));

        ctx_next              = ctx_reg;
        ctx_next.foreground   = req.foreground;
        ctx_next.background   = req.background;
        ctx_next.base_x       = base_x;
        ctx_next.pixel_y      = py;
        ctx_next.code_ok      = code_ok;
        ctx_next.ninth_repeat = (req.code[7:5] == 3'b110);

        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = draw_ok;
        end
        else if (take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            ctx_reg <= ctx_next;
        end
    end

    assign ctx_valid = s1_valid_reg;
    assign ctx       = ctx_reg;

`ifndef SYNTHESIS
    a_load_leaves_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.mode == tgr_pkg::MODE_LOAD) |=> !s1_valid_reg)
        else $error("load request left a draw context pending");

    a_read_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> s1_valid_reg)
        else $error("font read without a pending draw context");
`endif

endmodule
`default_nettype wire

@@ rtl/tgr_emit.sv @@
// Pixel emitter: walks one font row out as scaled pixels into the output register.
`default_nettype none
module tgr_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tgr_pkg::cfg_t cfg,
    input  wire logic          ctx_valid,
    input  wire tgr_pkg::ctx_t ctx,
    input  wire logic [7:0]    font_row,
    output logic               take,
    tgr_pix_if.source          pix
);

    logic                         active_reg;
    logic                         active_next;
    logic [5:0]                   gx_reg;
    logic [5:0]                   gx_next;
    logic [7:0]                   bits_reg;
    tgr_pkg::ctx_t                item_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [tgr_pkg::COORD_W-1:0]  out_x_reg;
    logic [tgr_pkg::COORD_W-1:0]  out_y_reg;
    logic [tgr_pkg::COLOR_W-1:0]  out_color_reg;
    logic                         out_canvas_reg;
    logic                         out_last_reg;

    logic                         adv;
    logic                         last;
    logic [5:0]                   cell_w;
    logic [3:0]                   fx;
    logic                         bit_set;
    logic [tgr_pkg::COLOR_W-1:0]  color_sel;
    logic [tgr_pkg::COORD_W-1:0]  x_pos;

    always_comb
    begin
        cell_w    = tgr_pkg::cell_width(cfg);
        last      = (gx_reg == cell_w - 6'd1);
        adv       = active_reg && (!out_valid_reg || pix.ready);
        take      = ctx_valid && (!active_reg || (adv && last));
        fx        = 4'(gx_reg >> tgr_pkg::eff_shift(cfg.scale_shift));
        bit_set   = fx[3] ? (item_reg.ninth_repeat && bits_reg[0]) : bits_reg[~fx[2:0]];
        color_sel = bit_set ? item_reg.foreground : item_reg.background;
        x_pos     = (item_reg.base_x + tgr_pkg::COORD_W'(gx_reg)) & tgr_pkg::COORD_MASK;

        active_next = active_reg;
        gx_next     = gx_reg;
        if (take)
        begin
            active_next = 1'b1;
            gx_next     = 6'd0;
        end
        else if (adv)
        begin
            active_next = !last;
            gx_next     = gx_reg + 6'd1;
        end

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            gx_reg        <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            gx_reg        <= gx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= ctx;
            // An out-of-range code draws as an all-clear glyph
            bits_reg <= ctx.code_ok ? font_row : 8'd0;
        end
        if (adv)
        begin
            out_x_reg      <= x_pos;
            out_y_reg      <= item_reg.pixel_y;
            out_color_reg  <= color_sel;
            out_canvas_reg <= cfg.canvas_enable && (color_sel == cfg.key_color);
            out_last_reg   <= last;
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.color       = out_color_reg;
    assign pix.from_canvas = out_canvas_reg;
    assign pix.last_pixel  = out_last_reg;

`ifndef SYNTHESIS
    a_count_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (gx_reg < cell_w))
        else $error("pixel counter ran past the cell width");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> pix.valid)
        else $error("advanced pixel did not reach the output register");

    a_take_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!active_reg || (adv && last)))
        else $error("new line taken while a line is still being emitted");
`endif

endmodule
`default_nettype wire

@@ rtl/text_glyph_row_renderer_unit.sv @@
// Top level of the text glyph row renderer: configuration registers and block wiring.
//
// Usage:
//   req carries load and draw requests (valid/ready). A load writes one font byte
//   into the 256 x 16 font store and gives no pixels. A draw on the grid emits one
//   scaled pixel line of a glyph on pix (valid/ready), one pixel per cycle while
//   pix.ready is high, left to right, last_pixel set on the final one.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes one register per
//   cycle and may be used only while no draw is in flight.
// Path: an accepted draw reads its font row from the font store into the pending
//   draw stage; the emitter then takes it and each pixel passes the output register.
// Throughput: one pixel per cycle from the emitter while pix.ready is high; a draw
//   occupies it for one cell width, 8, 9, 16, 18, 32 or 36 pixels (font columns
//   times scale); the next draw's font row is fetched meanwhile, so lines follow
//   with no gap. Loads are written into the font store as they are accepted.
// Reset: control and configuration registers take their defaults; the font store
//   is not cleared and must be loaded before glyphs are drawn.
// Stall: when pix.ready is low the output register holds its pixel, the emitter
//   stops, and req.ready falls once the pending draw stage is full.
`default_nettype none
module text_glyph_row_renderer_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [tgr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tgr_pkg::CFG_DATA_W-1:0]    cfg_data,
    tgr_req_if.sink                                req,
    tgr_pix_if.source                              pix
);

    tgr_pkg::cfg_t                cfg_reg;
    tgr_pkg::cfg_t                cfg_next;
    logic                         ram_we;
    logic [tgr_pkg::ADDR_W-1:0]   ram_waddr;
    logic [7:0]                   ram_wdata;
    logic                         ram_re;
    logic [tgr_pkg::ADDR_W-1:0]   ram_raddr;
    logic [7:0]                   ram_rdata;
    logic                         ctx_valid;
    tgr_pkg::ctx_t                ctx;
    logic                         take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tgr_pkg::CFG_ORIGIN_X:      cfg_next.origin_x      = cfg_data[12:0];
                tgr_pkg::CFG_ORIGIN_Y:      cfg_next.origin_y      = cfg_data[12:0];
                tgr_pkg::CFG_SCALE_SHIFT:   cfg_next.scale_shift   = cfg_data[1:0];
                tgr_pkg::CFG_NINTH_COLUMN:  cfg_next.ninth_column  = cfg_data[0];
                tgr_pkg::CFG_KEY_COLOR:     cfg_next.key_color     = cfg_data[31:0];
                tgr_pkg::CFG_CANVAS_ENABLE: cfg_next.canvas_enable = cfg_data[0];
                tgr_pkg::CFG_GRID_COLUMNS:  cfg_next.grid_columns  = cfg_data[7:0];
                tgr_pkg::CFG_GRID_ROWS:     cfg_next.grid_rows     = cfg_data[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= 13'd64;
            cfg_reg.origin_y      <= 13'd64;
            cfg_reg.scale_shift   <= 2'd0;
            cfg_reg.ninth_column  <= 1'b1;
            cfg_reg.key_color     <= 32'd0;
            cfg_reg.canvas_enable <= 1'b0;
            cfg_reg.grid_columns  <= 8'd80;
            cfg_reg.grid_rows     <= 8'd25;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tgr_fetch u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg_reg),
        .take      (take),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ctx_valid (ctx_valid),
        .ctx       (ctx)
    );

    tgr_ram #(
        .WIDTH (8),
        .DEPTH (tgr_pkg::STORE_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tgr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctx_valid (ctx_valid),
        .ctx       (ctx),
        .font_row  (ram_rdata),
        .take      (take),
        .pix       (pix)
    );

endmodule
`default_nettype wire
